### hdl/pin_vector_spi_master_defines.svh
// ----------------------------------------------------------------------------
// pin vector spi master assertion macros
// shared concurrent assertion forms used by the checker
// ----------------------------------------------------------------------------
`ifndef PIN_VECTOR_SPI_MASTER_DEFINES_SVH
`define PIN_VECTOR_SPI_MASTER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PVSPI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pvspi check failed");

// next-cycle implication, disabled while in reset
`define PVSPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pvspi check failed");

`endif

### hdl/pvspi_pkg.sv
// ----------------------------------------------------------------------------
// pvspi_pkg
// types, constants and helpers shared by the pin vector spi master
// ----------------------------------------------------------------------------
package pvspi_pkg;

  localparam int PinWidth     = 32;
  localparam int MaxBits      = 32;
  localparam int CountWidth   = 6;
  localparam int InDataWidth  = 104;
  localparam int OutDataWidth = 64;
  localparam int QueueDepth   = 2;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_START    = 2'd0,
    KIND_READBACK = 2'd1,
    KIND_SELECT   = 2'd2
  } kind_e;

  // result item kinds
  typedef enum logic {
    RES_DRIVE  = 1'b0,
    RES_FINISH = 1'b1
  } res_kind_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MOSI_MASK    = 3'd0,
    REG_MISO_MASK    = 3'd1,
    REG_CLOCK_MASK   = 3'd2,
    REG_SELECT_MASK  = 3'd3,
    REG_CLOCK_IDLE   = 3'd4,
    REG_SECOND_EDGE  = 3'd5,
    REG_SELECT_HIGH  = 3'd6,
    REG_LSB_FIRST    = 3'd7
  } reg_idx_e;

  // sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_WAIT_IDLE  = 3'd1,
    PH_WAIT_SETUP = 3'd2,
    PH_WAIT_EDGE1 = 3'd3,
    PH_WAIT_EDGE2 = 3'd4,
    PH_WAIT_FINAL = 3'd5,
    PH_WAIT_CS    = 3'd6
  } phase_e;

  // configuration as seen by front and back
  typedef struct packed {
    logic [PinWidth-1:0] mosi_mask;
    logic [PinWidth-1:0] miso_mask;
    logic [PinWidth-1:0] clock_mask;
    logic [PinWidth-1:0] select_mask;
    logic                clock_idle_high;
    logic                second_edge_sample;
    logic                select_active_high;
    logic                lsb_first;
  } cfg_t;

  // classified item held in the queue
  typedef struct packed {
    kind_e                 kind;
    logic [PinWidth-1:0]   other_pins;
    logic [MaxBits-1:0]    tx_bits;
    logic [CountWidth-1:0] bit_count;
    logic                  select_on;
    logic [PinWidth-1:0]   pins_in;
  } item_t;

  // ones in the low n bits, n from 1 to MaxBits
  function automatic logic [MaxBits-1:0] low_mask(logic [CountWidth-1:0] n);
    return ~({MaxBits{1'b1}} << n);
  endfunction

  // reverse the low n bits of v
  function automatic logic [MaxBits-1:0] rev_low(logic [MaxBits-1:0] v,
                                                 logic [CountWidth-1:0] n);
    logic [MaxBits-1:0] r;
    for (int i = 0; i < MaxBits; i++) begin
      r[i] = v[MaxBits-1-i];
    end
    return r >> (CountWidth'(MaxBits) - n);
  endfunction

endpackage

### hdl/pvspi_queue.sv
// ----------------------------------------------------------------------------
// pvspi_queue
// small register fifo between the classifying front and the sequencer
// ----------------------------------------------------------------------------
module pvspi_queue #(
  parameter int Depth = pvspi_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pvspi_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output pvspi_pkg::item_t pop_item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  pvspi_pkg::item_t      mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### hdl/pvspi_front.sv
// ----------------------------------------------------------------------------
// pvspi_front
// unpacks input items, drops unknown kinds, clamps the bit count and
// orders the outgoing word
// ----------------------------------------------------------------------------
module pvspi_front (
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic [1:0]                            in_kind_i,
  input  logic [pvspi_pkg::InDataWidth-1:0]     in_data_i,
  input  logic                                  lsb_first_i,
  output logic                                  push_o,
  output pvspi_pkg::item_t                      item_o
);

  logic [pvspi_pkg::CountWidth-1:0] raw_count;
  logic [pvspi_pkg::CountWidth-1:0] count;
  logic [pvspi_pkg::MaxBits-1:0]    tx_masked;
  logic                             known;

  // field unpacking, lowest field first
  assign raw_count = in_data_i[69:64];

  // clamp count into one to max bits
  always_comb begin
    if (raw_count == '0) begin
      count = pvspi_pkg::CountWidth'(1);
    end else if (raw_count > pvspi_pkg::CountWidth'(pvspi_pkg::MaxBits)) begin
      count = pvspi_pkg::CountWidth'(pvspi_pkg::MaxBits);
    end else begin
      count = raw_count;
    end
  end

  assign tx_masked = in_data_i[63:32] & pvspi_pkg::low_mask(count);

  // kind classification, the unused code is dropped here
  always_comb begin
    case (in_kind_i)
      pvspi_pkg::KIND_START,
      pvspi_pkg::KIND_READBACK,
      pvspi_pkg::KIND_SELECT: known = 1'b1;
      default:                known = 1'b0;
    endcase
  end

  assign push_o = in_valid_i && in_ready_i && known;

  always_comb begin
    item_o.kind       = pvspi_pkg::kind_e'(in_kind_i);
    item_o.other_pins = in_data_i[31:0];
    item_o.tx_bits    = lsb_first_i ? pvspi_pkg::rev_low(tx_masked, count) : tx_masked;
    item_o.bit_count  = count;
    item_o.select_on  = in_data_i[70];
    item_o.pins_in    = in_data_i[102:71];
  end

endmodule

### hdl/pvspi_back.sv
// ----------------------------------------------------------------------------
// pvspi_back
// transfer sequencer: walks the pin image through each transfer step and
// holds the result item in an output register
// ----------------------------------------------------------------------------
module pvspi_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pvspi_pkg::cfg_t                        cfg_i,
  input  logic                                   q_valid_i,
  input  pvspi_pkg::item_t                       q_item_i,
  output logic                                   q_pop_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   out_kind_o,
  output logic [pvspi_pkg::OutDataWidth-1:0]     out_data_o
);

  localparam int PW = pvspi_pkg::PinWidth;
  localparam int MB = pvspi_pkg::MaxBits;
  localparam int CW = pvspi_pkg::CountWidth;

  pvspi_pkg::phase_e phase_q, phase_d;
  logic [PW-1:0]     pin_q, pin_d;
  logic [MB-1:0]     tx_q, tx_d;
  logic [MB-1:0]     rx_q, rx_d;
  logic [CW-1:0]     left_q, left_d;
  logic [CW-1:0]     total_q, total_d;

  logic              out_valid_q, out_valid_d;
  logic              out_kind_q;
  logic [PW-1:0]     out_pins_q;
  logic [MB-1:0]     out_rx_q;

  logic              emit;
  logic              res_kind;
  logic [MB-1:0]     res_rx;

  // take the next item once the output register can hold its result
  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // drive select pins asserted or released
  function automatic logic [PW-1:0] put_select(logic [PW-1:0] img, logic on,
                                               pvspi_pkg::cfg_t c);
    logic high;
    high = on ? c.select_active_high : !c.select_active_high;
    return high ? (img | c.select_mask) : (img & ~c.select_mask);
  endfunction

  // one sequencer step for the popped item
  always_comb begin
    logic [CW-1:0] top;
    logic          bit_v;
    phase_d  = phase_q;
    pin_d    = pin_q;
    tx_d     = tx_q;
    rx_d     = rx_q;
    left_d   = left_q;
    total_d  = total_q;
    emit     = 1'b0;
    res_kind = pvspi_pkg::RES_DRIVE;
    res_rx   = '0;
    top      = total_q - CW'(1);
    bit_v    = tx_q[top[CW-2:0]];
    case (q_item_i.kind)
      pvspi_pkg::KIND_START: begin
        if (phase_q == pvspi_pkg::PH_IDLE) begin
          total_d = q_item_i.bit_count;
          left_d  = q_item_i.bit_count;
          tx_d    = q_item_i.tx_bits;
          rx_d    = '0;
          pin_d   = cfg_i.clock_idle_high ? (q_item_i.other_pins | cfg_i.clock_mask)
                                          : (q_item_i.other_pins & ~cfg_i.clock_mask);
          phase_d = pvspi_pkg::PH_WAIT_IDLE;
          emit    = 1'b1;
        end
      end
      pvspi_pkg::KIND_SELECT: begin
        if (phase_q == pvspi_pkg::PH_IDLE) begin
          pin_d   = put_select(q_item_i.other_pins, q_item_i.select_on, cfg_i);
          phase_d = pvspi_pkg::PH_WAIT_CS;
          emit    = 1'b1;
        end
      end
      pvspi_pkg::KIND_READBACK: begin
        case (phase_q)
          pvspi_pkg::PH_WAIT_IDLE: begin
            pin_d = put_select(pin_q, 1'b1, cfg_i);
            if (!cfg_i.second_edge_sample) begin
              pin_d = bit_v ? (pin_d | cfg_i.mosi_mask) : (pin_d & ~cfg_i.mosi_mask);
              tx_d  = (tx_q << 1) & pvspi_pkg::low_mask(total_q);
            end
            phase_d = pvspi_pkg::PH_WAIT_SETUP;
            emit    = 1'b1;
          end
          pvspi_pkg::PH_WAIT_SETUP: begin
            pin_d = pin_q ^ cfg_i.clock_mask;
            if (cfg_i.second_edge_sample) begin
              pin_d = bit_v ? (pin_d | cfg_i.mosi_mask) : (pin_d & ~cfg_i.mosi_mask);
              tx_d  = (tx_q << 1) & pvspi_pkg::low_mask(total_q);
            end
            phase_d = pvspi_pkg::PH_WAIT_EDGE1;
            emit    = 1'b1;
          end
          pvspi_pkg::PH_WAIT_EDGE1: begin
            pin_d = pin_q ^ cfg_i.clock_mask;
            if (!cfg_i.second_edge_sample) begin
              rx_d  = ((rx_q << 1) | MB'(|(q_item_i.pins_in & cfg_i.miso_mask)))
                      & pvspi_pkg::low_mask(total_q);
              pin_d = bit_v ? (pin_d | cfg_i.mosi_mask) : (pin_d & ~cfg_i.mosi_mask);
              tx_d  = (tx_q << 1) & pvspi_pkg::low_mask(total_q);
            end
            phase_d = pvspi_pkg::PH_WAIT_EDGE2;
            emit    = 1'b1;
          end
          pvspi_pkg::PH_WAIT_EDGE2: begin
            if (cfg_i.second_edge_sample) begin
              rx_d = ((rx_q << 1) | MB'(|(q_item_i.pins_in & cfg_i.miso_mask)))
                     & pvspi_pkg::low_mask(total_q);
            end
            left_d = (left_q != '0) ? left_q - CW'(1) : left_q;
            if (left_d != '0) begin
              pin_d = pin_q ^ cfg_i.clock_mask;
              if (cfg_i.second_edge_sample) begin
                pin_d = bit_v ? (pin_d | cfg_i.mosi_mask) : (pin_d & ~cfg_i.mosi_mask);
                tx_d  = (tx_q << 1) & pvspi_pkg::low_mask(total_q);
              end
              phase_d = pvspi_pkg::PH_WAIT_EDGE1;
            end else begin
              phase_d = pvspi_pkg::PH_WAIT_FINAL;
            end
            emit = 1'b1;
          end
          pvspi_pkg::PH_WAIT_FINAL: begin
            res_rx   = cfg_i.lsb_first ? pvspi_pkg::rev_low(rx_q, total_q) : rx_q;
            res_kind = pvspi_pkg::RES_FINISH;
            phase_d  = pvspi_pkg::PH_IDLE;
            emit     = 1'b1;
          end
          pvspi_pkg::PH_WAIT_CS: begin
            res_kind = pvspi_pkg::RES_FINISH;
            phase_d  = pvspi_pkg::PH_IDLE;
            emit     = 1'b1;
          end
          default: begin
            // readback while idle is ignored
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // output register handshake
  always_comb begin
    if (q_pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pvspi_pkg::PH_IDLE;
      pin_q       <= '0;
      tx_q        <= '0;
      rx_q        <= '0;
      left_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        phase_q <= phase_d;
        pin_q   <= pin_d;
        tx_q    <= tx_d;
        rx_q    <= rx_d;
        left_q  <= left_d;
        total_q <= total_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o && emit) begin
      out_kind_q <= res_kind;
      out_pins_q <= pin_d;
      out_rx_q   <= res_rx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = {out_rx_q, out_pins_q};

endmodule

### hdl/pin_vector_spi_master.sv
// Throughput: one item per cycle, sustained while the result side takes items.
// Each result passes through one register stage in the queue and one in the
//   output register before it is shown.
// The queue depth sets how many items the front takes while the output stalls.
// Reset clears configuration, sequencer state, queue and output valid at once.
// ----------------------------------------------------------------------------
// pin_vector_spi_master
// bit-banged spi master over a 32-bit pin vector with stream ports
// ----------------------------------------------------------------------------
module pin_vector_spi_master #(
  parameter int QueueDepth = pvspi_pkg::QueueDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [2:0]                          cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  // input items
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // other_pins, tx_data, bit_count, select_on, pins_in, zero fill
  input  logic [pvspi_pkg::InDataWidth-1:0]   s_axis_tdata_i,
  // kind
  input  logic [1:0]                          s_axis_tuser_i,
  // result items
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // pins_out, rx_data
  output logic [pvspi_pkg::OutDataWidth-1:0]  m_axis_tdata_o,
  // result_kind
  output logic                                m_axis_tuser_o
);

  pvspi_pkg::cfg_t  cfg_q, cfg_d;
  pvspi_pkg::item_t push_item, pop_item;
  logic             push, pop, q_full, q_valid;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !q_full;

  // configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (pvspi_pkg::reg_idx_e'(cfg_index_i))
        pvspi_pkg::REG_MOSI_MASK:   cfg_d.mosi_mask          = cfg_data_i;
        pvspi_pkg::REG_MISO_MASK:   cfg_d.miso_mask          = cfg_data_i;
        pvspi_pkg::REG_CLOCK_MASK:  cfg_d.clock_mask         = cfg_data_i;
        pvspi_pkg::REG_SELECT_MASK: cfg_d.select_mask        = cfg_data_i;
        pvspi_pkg::REG_CLOCK_IDLE:  cfg_d.clock_idle_high    = cfg_data_i[0];
        pvspi_pkg::REG_SECOND_EDGE: cfg_d.second_edge_sample = cfg_data_i[0];
        pvspi_pkg::REG_SELECT_HIGH: cfg_d.select_active_high = cfg_data_i[0];
        pvspi_pkg::REG_LSB_FIRST:   cfg_d.lsb_first          = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classify and queue
  pvspi_front u_front (
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_i  (s_axis_tready_o),
    .in_kind_i   (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .lsb_first_i (cfg_q.lsb_first),
    .push_o      (push),
    .item_o      (push_item)
  );

  pvspi_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  // sequencer and result register
  pvspi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (m_axis_tuser_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

### hdl/pvspi_checker.sv
// ----------------------------------------------------------------------------
// pvspi_checker
// port-level checks of the pin vector spi master, bound to the top level
// ----------------------------------------------------------------------------
`include "pin_vector_spi_master_defines.svh"

module pvspi_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic                                s_axis_tvalid_i,
  input logic                                s_axis_tready_o,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i,
  input logic [pvspi_pkg::OutDataWidth-1:0]  m_axis_tdata_o,
  input logic                                m_axis_tuser_o
);

  logic                             out_stalled;
  logic [pvspi_pkg::OutDataWidth:0] out_word;
  logic                             drive_shown;
  logic [pvspi_pkg::MaxBits-1:0]    rx_word;
  logic                             in_accept;

  assign out_stalled = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_word    = {m_axis_tuser_o, m_axis_tdata_o};
  assign drive_shown = m_axis_tvalid_o && (m_axis_tuser_o == pvspi_pkg::RES_DRIVE);
  assign rx_word     = m_axis_tdata_o[pvspi_pkg::OutDataWidth-1:pvspi_pkg::PinWidth];
  assign in_accept   = s_axis_tvalid_i && s_axis_tready_o;

  // a stalled result item holds
  `PVSPI_ASSERT_NEXT(a_out_hold, out_stalled, m_axis_tvalid_o && $stable(out_word))

  // drive result items carry no received word
  `PVSPI_ASSERT_NOW(a_drive_rx_zero, drive_shown, rx_word == '0)

  // the queue only fills up after an item was taken
  `PVSPI_ASSERT_NOW(a_full_after_accept, $fell(s_axis_tready_o), $past(in_accept))

  // configuration writes are never stalled
  `PVSPI_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind pin_vector_spi_master pvspi_checker u_checker (.*);
